[sv/iee_pkg.sv]
// Types, character codes and state encodings of the infix expression evaluator.
package iee_pkg;

  localparam int unsigned DataW = 32;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_CHAR  = 2'd1,
    ST_NO_NUMBER = 2'd2,
    ST_DIV_ZERO  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PH_EXPECT = 2'd0,
    PH_NUMBER = 2'd1,
    PH_AFTER  = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    MP_NONE = 2'd0,
    MP_MUL  = 2'd1,
    MP_DIV  = 2'd2
  } mul_op_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_DIV  = 2'd2,
    S_FIX  = 2'd3
  } state_e;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_line;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    status_e                 status;
  } out_item_t;

endpackage

[sv/infix_expression_evaluator.sv]
// Streaming evaluator of one line of integer arithmetic, one character per transaction.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------
//  in      | input     | in_valid_i/in_stall_o  | iee_pkg::in_item_t  (char, eol)
//  out     | output    | out_valid_o/out_stall_i| iee_pkg::out_item_t (value, status)
//
// A character is taken, then executed; one that ends a literal is folded first, then executed.
// One that ends a divisor adds set-up, the shared restoring divider, which retires
// one quotient bit a cycle, and a sign fix before the character is executed.
// End of line writes the output register; it waits there while out_stall_i holds
// a previous result, and the input stays stalled meanwhile.
// Reset (rst_ni low, asynchronous) leaves the block idle, ready for a new line.
module infix_expression_evaluator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  iee_pkg::in_item_t   in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output iee_pkg::out_item_t  out_o
);

  localparam int unsigned W = iee_pkg::DataW;
  localparam int unsigned CntW = $clog2(W);

  iee_pkg::state_e    state_q, state_d;
  iee_pkg::in_item_t  item_q, item_d;
  iee_pkg::phase_e    phase_q, phase_d;
  iee_pkg::mul_op_e   mul_q, mul_d;
  iee_pkg::status_e   error_q, error_d;
  logic               add_neg_q, add_neg_d;
  logic [W-1:0]       sum_q, sum_d;
  logic [W-1:0]       product_q, product_d;
  logic [W-1:0]       number_q, number_d;

  // divider
  logic [W-1:0]       div_rem_q, div_rem_d;
  logic [W-1:0]       div_quo_q, div_quo_d;
  logic               div_neg_q, div_neg_d;
  logic [CntW-1:0]    div_cnt_q, div_cnt_d;

  logic               out_valid_q, out_valid_d;
  iee_pkg::out_item_t out_q, out_d;

  logic [7:0]   ch;
  logic         eol;
  logic         is_digit;
  logic [3:0]   digit_val;
  logic         finish;
  logic         div_start;
  logic         out_free;
  logic [W-1:0] total;
  logic [W-1:0] mul_res;
  logic [W:0]   rem_shift;
  logic [W:0]   rem_diff;
  logic         rem_ge;

  assign ch        = item_q.char_byte;
  assign eol       = item_q.end_of_line;
  assign is_digit  = (ch >= iee_pkg::CH_ZERO) && (ch <= iee_pkg::CH_NINE);
  assign digit_val = ch[3:0];
  assign out_free  = !out_valid_q || !out_stall_i;
  assign total     = add_neg_q ? (sum_q - product_q) : (sum_q + product_q);
  assign mul_res   = product_q * number_q;

  // literal complete: fold it into the open term before handling the character
  assign finish    = (state_q == iee_pkg::S_EXEC) && (error_q == iee_pkg::ST_OK) &&
                     (phase_q == iee_pkg::PH_NUMBER) && (eol || !is_digit);
  assign div_start = finish && (mul_q == iee_pkg::MP_DIV) && (number_q != '0);

  // one restoring step; number_q holds the divisor magnitude while dividing
  assign rem_shift = {div_rem_q, div_quo_q[W-1]};
  assign rem_diff  = rem_shift - {1'b0, number_q};
  assign rem_ge    = !rem_diff[W];

  assign in_stall_o  = (state_q != iee_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      iee_pkg::S_IDLE: begin
        if (in_valid_i) state_d = iee_pkg::S_EXEC;
      end
      iee_pkg::S_EXEC: begin
        if (div_start) begin
          state_d = iee_pkg::S_DIV;
        end else if (finish) begin
          state_d = iee_pkg::S_EXEC;
        end else if (eol && !out_free) begin
          state_d = iee_pkg::S_EXEC;
        end else begin
          state_d = iee_pkg::S_IDLE;
        end
      end
      iee_pkg::S_DIV: begin
        if (div_cnt_q == CntW'(W - 1)) state_d = iee_pkg::S_FIX;
      end
      iee_pkg::S_FIX: state_d = iee_pkg::S_EXEC;
      default: state_d = iee_pkg::S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    item_d      = item_q;
    phase_d     = phase_q;
    mul_d       = mul_q;
    error_d     = error_q;
    add_neg_d   = add_neg_q;
    sum_d       = sum_q;
    product_d   = product_q;
    number_d    = number_q;
    div_rem_d   = div_rem_q;
    div_quo_d   = div_quo_q;
    div_neg_d   = div_neg_q;
    div_cnt_d   = div_cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    case (state_q)
      iee_pkg::S_IDLE: begin
        if (in_valid_i) item_d = in_i;
      end
      iee_pkg::S_EXEC: begin
        if (finish) begin
          case (mul_q)
            iee_pkg::MP_MUL: begin
              product_d = mul_res;
              mul_d     = iee_pkg::MP_NONE;
              number_d  = '0;
              phase_d   = iee_pkg::PH_AFTER;
            end
            iee_pkg::MP_DIV: begin
              if (number_q == '0) begin
                error_d = iee_pkg::ST_DIV_ZERO;
              end else begin
                div_rem_d = '0;
                div_quo_d = product_q[W-1] ? (W'(0) - product_q) : product_q;
                number_d  = number_q[W-1] ? (W'(0) - number_q) : number_q;
                div_neg_d = product_q[W-1] ^ number_q[W-1];
                div_cnt_d = '0;
              end
            end
            default: begin
              product_d = number_q;
              mul_d     = iee_pkg::MP_NONE;
              number_d  = '0;
              phase_d   = iee_pkg::PH_AFTER;
            end
          endcase
        end else if (eol) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            if (error_q == iee_pkg::ST_OK && phase_q == iee_pkg::PH_EXPECT) begin
              out_d.status = iee_pkg::ST_NO_NUMBER;
              out_d.value  = '0;
            end else if (error_q == iee_pkg::ST_OK) begin
              out_d.status = iee_pkg::ST_OK;
              out_d.value  = total;
            end else begin
              out_d.status = error_q;
              out_d.value  = '0;
            end
            phase_d   = iee_pkg::PH_EXPECT;
            mul_d     = iee_pkg::MP_NONE;
            error_d   = iee_pkg::ST_OK;
            add_neg_d = 1'b0;
            sum_d     = '0;
            product_d = '0;
            number_d  = '0;
          end
        end else if (error_q != iee_pkg::ST_OK || phase_q == iee_pkg::PH_DONE) begin
          // rest of the line is ignored
        end else if (phase_q == iee_pkg::PH_NUMBER) begin
          number_d = (number_q << 3) + (number_q << 1) + W'(digit_val);
        end else if (ch == iee_pkg::CH_SPACE) begin
          // skipped
        end else if (phase_q == iee_pkg::PH_EXPECT) begin
          if (is_digit) begin
            number_d = W'(digit_val);
            phase_d  = iee_pkg::PH_NUMBER;
          end else if (ch == iee_pkg::CH_NUL || ch == iee_pkg::CH_PLUS ||
                       ch == iee_pkg::CH_MINUS || ch == iee_pkg::CH_STAR ||
                       ch == iee_pkg::CH_SLASH) begin
            error_d = iee_pkg::ST_NO_NUMBER;
          end else begin
            error_d = iee_pkg::ST_BAD_CHAR;
          end
        end else begin
          if (ch == iee_pkg::CH_STAR) begin
            mul_d   = iee_pkg::MP_MUL;
            phase_d = iee_pkg::PH_EXPECT;
          end else if (ch == iee_pkg::CH_SLASH) begin
            mul_d   = iee_pkg::MP_DIV;
            phase_d = iee_pkg::PH_EXPECT;
          end else if (ch == iee_pkg::CH_PLUS || ch == iee_pkg::CH_MINUS) begin
            sum_d     = total;
            add_neg_d = (ch == iee_pkg::CH_MINUS);
            product_d = '0;
            mul_d     = iee_pkg::MP_NONE;
            phase_d   = iee_pkg::PH_EXPECT;
          end else if (is_digit || ch == iee_pkg::CH_NUL) begin
            phase_d = iee_pkg::PH_DONE;
          end else begin
            error_d = iee_pkg::ST_BAD_CHAR;
          end
        end
      end
      iee_pkg::S_DIV: begin
        div_rem_d = rem_ge ? rem_diff[W-1:0] : rem_shift[W-1:0];
        div_quo_d = {div_quo_q[W-2:0], rem_ge};
        div_cnt_d = div_cnt_q + CntW'(1);
      end
      iee_pkg::S_FIX: begin
        product_d = div_neg_q ? (W'(0) - div_quo_q) : div_quo_q;
        mul_d     = iee_pkg::MP_NONE;
        number_d  = '0;
        phase_d   = iee_pkg::PH_AFTER;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= iee_pkg::S_IDLE;
      phase_q     <= iee_pkg::PH_EXPECT;
      mul_q       <= iee_pkg::MP_NONE;
      error_q     <= iee_pkg::ST_OK;
      add_neg_q   <= 1'b0;
      sum_q       <= '0;
      product_q   <= '0;
      number_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      mul_q       <= mul_d;
      error_q     <= error_d;
      add_neg_q   <= add_neg_d;
      sum_q       <= sum_d;
      product_q   <= product_d;
      number_q    <= number_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    div_rem_q <= div_rem_d;
    div_quo_q <= div_quo_d;
    div_neg_q <= div_neg_d;
    div_cnt_q <= div_cnt_d;
    out_q     <= out_d;
  end

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == iee_pkg::S_DIV) |-> (number_q != '0))
    else $error("divide running with zero divisor");

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == iee_pkg::S_DIV && div_cnt_q == CntW'(W - 1)) |=> (state_q == iee_pkg::S_FIX))
    else $error("divide did not end after its last quotient bit");

  a_err_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != iee_pkg::ST_OK) |-> (out_q.value == '0))
    else $error("error result with nonzero value");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (error_q != iee_pkg::ST_OK && state_q != iee_pkg::S_EXEC) |=> (error_q == $past(error_q)))
    else $error("error code changed outside execution");

endmodule

[tb/sv/infix_expression_evaluator_tb.sv]
// Self-checking testbench for the infix expression evaluator, with its own line predictor.
`timescale 1ns / 100ps

module infix_expression_evaluator_tb;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ItemTarget = 1600;
  localparam int unsigned DrainCycles = 40;

  typedef struct packed {
    logic [7:0]       ch;
    logic             eol;
    logic             typed;
    logic [31:0]      value;
    iee_pkg::status_e status;
  } row_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  iee_pkg::in_item_t  in_i        = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  iee_pkg::out_item_t out_o;

  bit          calm       = 1'b0;
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned cycles     = 0;

  iee_pkg::out_item_t line_results_q[$];
  logic [7:0]         line_chars[$];
  logic [7:0]         punct [6] = '{iee_pkg::CH_PLUS, iee_pkg::CH_MINUS, iee_pkg::CH_STAR,
                                    iee_pkg::CH_SLASH, iee_pkg::CH_SPACE, iee_pkg::CH_NUL};

  // Directed lines; typed rows carry the expected result of the line
  row_t directed_rows [26] = '{
    // empty line
    '{iee_pkg::CH_NUL, 1'b1, 1'b1, 32'd0, iee_pkg::ST_NO_NUMBER},
    // bad byte first, later operator must not override it
    '{8'hFF, 1'b0, 1'b0, 32'd0, iee_pkg::ST_OK},
    '{iee_pkg::CH_SLASH, 1'b0, 1'b0, 32'd0, iee_pkg::ST_OK},
    '{8'hFF, 1'b1, 1'b1, 32'd0, iee_pkg::ST_BAD_CHAR},
    // divisor completed by end of line
    '{iee_pkg::CH_ZERO + 8'd8, 1'b0, 1'b0, 32'd0, iee_pkg::ST_OK},
    '{iee_pkg::CH_SLASH, 1'b0, 1'b0, 32'd0, iee_pkg::ST_OK},
    '{iee_pkg::CH_ZERO, 1'b0, 1'b0, 32'd0, iee_pkg::ST_OK},
    '{iee_pkg::CH_NUL, 1'b1, 1'b1, 32'd0, iee_pkg::ST_DIV_ZERO},
    // second literal without an operator ends evaluation
    '{iee_pkg::CH_NINE, 1'b0, 1'b0, 32'd0, iee_pkg::ST_OK},
    '{iee_pkg::CH_SPACE, 1'b0, 1'b0, 32'd0, iee_pkg::ST_OK},
    '{iee_pkg::CH_ZERO + 8'd3, 1'b0, 1'b0, 32'd0, iee_pkg::ST_OK},
    '{iee_pkg::CH_NUL, 1'b1, 1'b1, 32'd9, iee_pkg::ST_OK},
    // NUL terminates, junk after it ignored
    '{iee_pkg::CH_ZERO + 8'd6, 1'b0, 1'b0, 32'd0, iee_pkg::ST_OK},
    '{iee_pkg::CH_STAR, 1'b0, 1'b0, 32'd0, iee_pkg::ST_OK},
    '{iee_pkg::CH_ZERO + 8'd7, 1'b0, 1'b0, 32'd0, iee_pkg::ST_OK},
    '{iee_pkg::CH_NUL, 1'b0, 1'b0, 32'd0, iee_pkg::ST_OK},
    '{8'h78, 1'b0, 1'b0, 32'd0, iee_pkg::ST_OK},
    '{iee_pkg::CH_NUL, 1'b1, 1'b1, 32'd42, iee_pkg::ST_OK},
    // precedence mix
    '{iee_pkg::CH_ZERO + 8'd1, 1'b0, 1'b0, 32'd0, iee_pkg::ST_OK},
    '{iee_pkg::CH_PLUS, 1'b0, 1'b0, 32'd0, iee_pkg::ST_OK},
    '{iee_pkg::CH_NINE, 1'b0, 1'b0, 32'd0, iee_pkg::ST_OK},
    '{iee_pkg::CH_SLASH, 1'b0, 1'b0, 32'd0, iee_pkg::ST_OK},
    '{iee_pkg::CH_ZERO + 8'd2, 1'b0, 1'b0, 32'd0, iee_pkg::ST_OK},
    '{iee_pkg::CH_MINUS, 1'b0, 1'b0, 32'd0, iee_pkg::ST_OK},
    '{iee_pkg::CH_ZERO + 8'd3, 1'b0, 1'b0, 32'd0, iee_pkg::ST_OK},
    '{8'h00, 1'b1, 1'b0, 32'd0, iee_pkg::ST_OK}
  };

  // Predictor state
  iee_pkg::phase_e  ev_phase = iee_pkg::PH_EXPECT;
  logic [31:0]      ev_sum   = '0;
  logic             ev_minus = 1'b0;
  logic [31:0]      ev_term  = '0;
  iee_pkg::mul_op_e ev_mop   = iee_pkg::MP_NONE;
  logic [31:0]      ev_lit   = '0;
  iee_pkg::status_e ev_err   = iee_pkg::ST_OK;

  infix_expression_evaluator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [31:0] quot_trunc(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ma;
    logic [31:0] mb;
    logic [31:0] q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q  = ma / mb;
    return (a[31] ^ b[31]) ? -q : q;
  endfunction

  function automatic logic [31:0] line_total();
    return ev_minus ? ev_sum - ev_term : ev_sum + ev_term;
  endfunction

  // Close the literal into the open term; a zero divisor only records the error
  function automatic void fold_literal();
    if (ev_mop == iee_pkg::MP_MUL) begin
      ev_term = ev_term * ev_lit;
    end else if (ev_mop == iee_pkg::MP_DIV) begin
      if (ev_lit == '0) begin
        ev_err = iee_pkg::ST_DIV_ZERO;
        return;
      end
      ev_term = quot_trunc(ev_term, ev_lit);
    end else begin
      ev_term = ev_lit;
    end
    ev_mop   = iee_pkg::MP_NONE;
    ev_lit   = '0;
    ev_phase = iee_pkg::PH_AFTER;
  endfunction

  function automatic bit eval_char(input iee_pkg::in_item_t it,
                                   output iee_pkg::out_item_t res);
    logic [7:0] ch;
    bit         dig;
    ch  = it.char_byte;
    dig = (ch >= iee_pkg::CH_ZERO) && (ch <= iee_pkg::CH_NINE);
    res = '0;
    if (it.end_of_line) begin
      if (ev_err == iee_pkg::ST_OK && ev_phase == iee_pkg::PH_NUMBER) fold_literal();
      if (ev_err == iee_pkg::ST_OK && ev_phase == iee_pkg::PH_EXPECT)
        ev_err = iee_pkg::ST_NO_NUMBER;
      res.status = ev_err;
      res.value  = (ev_err == iee_pkg::ST_OK) ? line_total() : '0;
      ev_phase = iee_pkg::PH_EXPECT;
      ev_sum   = '0;
      ev_minus = 1'b0;
      ev_term  = '0;
      ev_mop   = iee_pkg::MP_NONE;
      ev_lit   = '0;
      ev_err   = iee_pkg::ST_OK;
      return 1'b1;
    end
    if (ev_err != iee_pkg::ST_OK || ev_phase == iee_pkg::PH_DONE) return 1'b0;
    if (ev_phase == iee_pkg::PH_NUMBER) begin
      if (dig) begin
        ev_lit = ev_lit * 32'd10 + {24'd0, 8'(ch - iee_pkg::CH_ZERO)};
        return 1'b0;
      end
      fold_literal();
      if (ev_err != iee_pkg::ST_OK) return 1'b0;
    end
    if (ch == iee_pkg::CH_SPACE) return 1'b0;
    if (ev_phase == iee_pkg::PH_EXPECT) begin
      if (dig) begin
        ev_lit   = {24'd0, 8'(ch - iee_pkg::CH_ZERO)};
        ev_phase = iee_pkg::PH_NUMBER;
      end else if (ch == iee_pkg::CH_NUL || ch == iee_pkg::CH_PLUS ||
                   ch == iee_pkg::CH_MINUS || ch == iee_pkg::CH_STAR ||
                   ch == iee_pkg::CH_SLASH) begin
        ev_err = iee_pkg::ST_NO_NUMBER;
      end else begin
        ev_err = iee_pkg::ST_BAD_CHAR;
      end
      return 1'b0;
    end
    // after a literal
    if (ch == iee_pkg::CH_STAR) begin
      ev_mop   = iee_pkg::MP_MUL;
      ev_phase = iee_pkg::PH_EXPECT;
    end else if (ch == iee_pkg::CH_SLASH) begin
      ev_mop   = iee_pkg::MP_DIV;
      ev_phase = iee_pkg::PH_EXPECT;
    end else if (ch == iee_pkg::CH_PLUS || ch == iee_pkg::CH_MINUS) begin
      ev_sum   = line_total();
      ev_minus = (ch == iee_pkg::CH_MINUS);
      ev_term  = '0;
      ev_mop   = iee_pkg::MP_NONE;
      ev_phase = iee_pkg::PH_EXPECT;
    end else if (dig || ch == iee_pkg::CH_NUL) begin
      ev_phase = iee_pkg::PH_DONE;
    end else begin
      ev_err = iee_pkg::ST_BAD_CHAR;
    end
    return 1'b0;
  endfunction

  task automatic flag_result(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // One transaction on the input channel; prediction happens on acceptance
  task automatic push_char(input logic [7:0] ch, input logic eol, input bit typed,
                           input iee_pkg::out_item_t typed_res);
    iee_pkg::in_item_t  it;
    iee_pkg::out_item_t res;
    bit                 emits;
    it.char_byte   = ch;
    it.end_of_line = eol;
    while (!calm && $urandom_range(0, 99) < 6) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    emits = eval_char(it, res);
    if (emits) line_results_q.push_back(typed ? typed_res : res);
    items_sent++;
  endtask

  task automatic append_literal();
    logic [31:0] v;
    logic [7:0]  digits[$];
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = 32'd1;
      2, 3, 4: v = $urandom_range(2, 99);
      5:       v = $urandom_range(100, 9999);
      6:       v = '1;               // wraps to -1
      7:       v = 32'h8000_0000;    // wraps to the minimum value
      default: begin
        repeat ($urandom_range(10, 12))
          line_chars.push_back(iee_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        return;
      end
    endcase
    do begin
      digits.push_front(iee_pkg::CH_ZERO + 8'(v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (digits[i]) line_chars.push_back(digits[i]);
  endtask

  // Mostly well-formed lines with random literals, the rest broken or noise
  task automatic build_line();
    int unsigned terms;
    logic [7:0]  c;
    line_chars.delete();
    if ($urandom_range(0, 99) < 80) begin
      terms = $urandom_range(1, 5);
      for (int t = 0; t < terms; t++) begin
        if (t != 0) begin
          if ($urandom_range(0, 4) == 0) line_chars.push_back(iee_pkg::CH_SPACE);
          line_chars.push_back(punct[$urandom_range(0, 3)]);
          if ($urandom_range(0, 4) == 0) line_chars.push_back(iee_pkg::CH_SPACE);
        end
        append_literal();
      end
      case ($urandom_range(0, 19))
        0: line_chars[$urandom_range(0, line_chars.size() - 1)] = 8'($urandom_range(0, 255));
        1: line_chars.push_back(punct[$urandom_range(0, 3)]);
        2: begin
          line_chars.push_back(iee_pkg::CH_NUL);
          line_chars.push_back(8'($urandom_range(0, 255)));
        end
        3: begin
          line_chars.push_back(iee_pkg::CH_SPACE);
          append_literal();
        end
        default: ;
      endcase
    end else begin
      repeat ($urandom_range(0, 6)) begin
        case ($urandom_range(0, 2))
          0:       c = 8'($urandom_range(0, 255));
          1:       c = iee_pkg::CH_ZERO + 8'($urandom_range(0, 9));
          default: c = punct[$urandom_range(0, 5)];
        endcase
        line_chars.push_back(c);
      end
    end
  endtask

  always @(posedge clk_i) begin : result_check
    iee_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (line_results_q.size() == 0) begin
        flag_result($sformatf("unexpected result value=%0d status=%s",
                              out_o.value, out_o.status.name()));
      end else begin
        want = line_results_q.pop_front();
        if (want.value !== out_o.value || want.status !== out_o.status)
          flag_result($sformatf("result mismatch: value exp %0d got %0d, status exp %s got %s",
                                want.value, out_o.value, want.status.name(),
                                out_o.status.name()));
      end
    end
    out_stall_i <= !calm && ($urandom_range(0, 99) < 6);
  end

  initial begin : watchdog
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("[infix_expression_evaluator] ERROR");
    $finish;
  end

  initial begin : stimulus
    iee_pkg::out_item_t typed_res;
    int unsigned        lines;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (directed_rows[i]) begin
      typed_res.value  = directed_rows[i].value;
      typed_res.status = directed_rows[i].status;
      push_char(directed_rows[i].ch, directed_rows[i].eol, directed_rows[i].typed, typed_res);
    end
    lines = 0;
    while (items_sent < ItemTarget) begin
      // a stretch of lines with no idling on either side
      calm = (lines >= 40) && (lines < 70);
      build_line();
      foreach (line_chars[k]) push_char(line_chars[k], 1'b0, 1'b0, '0);
      push_char(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
      lines++;
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;
    while (line_results_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[infix_expression_evaluator] OK");
    end else begin
      $display("[infix_expression_evaluator] ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
sv/iee_pkg.sv
sv/infix_expression_evaluator.sv
tb/sv/infix_expression_evaluator_tb.sv
